@@ src/lcd_pkg.sv @@
// ----------------------------------------------------------------------------
// lcd_pkg
// Shared types, field positions and constants for the lane change decision
// block.
// ----------------------------------------------------------------------------
package lcd_pkg;

	// item kinds carried in s_tuser
	typedef enum logic [1:0] {
		ACT_BEGIN   = 2'd0,
		ACT_VEHICLE = 2'd1,
		ACT_FINISH  = 2'd2,
		ACT_NONE    = 2'd3
	} lcd_action_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_FOLLOW_GAP  = 3'd0,
		REG_REAR_GAP    = 3'd1,
		REG_SPEED_STEP  = 3'd2,
		REG_SPEED_LIMIT = 3'd3,
		REG_POINT_MS    = 3'd4,
		REG_LANE_COUNT  = 3'd5,
		REG_SPARE6      = 3'd6,
		REG_SPARE7      = 3'd7
	} lcd_reg_t;

	typedef enum logic [1:0] {
		TOP_IDLE,
		TOP_BUSY,
		TOP_HOLD
	} lcd_top_state_t;

	typedef enum logic [2:0] {
		U_IDLE,
		U_SQA,
		U_SQB,
		U_ROOT,
		U_PP,
		U_PS,
		U_DIV,
		U_GAP
	} lcd_unit_state_t;

	// per-vehicle verdict from the iterative unit
	typedef struct packed {
		logic              done;
		logic              close;
		logic              ahead;
		logic signed [3:0] clane;
	} lcd_vstat_t;

	localparam int IN_DATA_W  = 128;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 24;

	// input tdata bit positions
	localparam int EGO_S_LO   = 0;
	localparam int EGO_LANE_LO = 24;
	localparam int REF_SPD_LO = 27;
	localparam int POINTS_LO  = 43;
	localparam int CAR_S_LO   = 51;
	localparam int CAR_D_LO   = 75;
	localparam int CAR_VX_LO  = 89;
	localparam int CAR_VY_LO  = 105;

	localparam logic [15:0] FOLLOW_GAP_RST  = 16'd7680;
	localparam logic [15:0] REAR_GAP_RST    = 16'd2560;
	localparam logic [11:0] SPEED_STEP_RST  = 12'd224;
	localparam logic [15:0] SPEED_LIMIT_RST = 16'd49500;
	localparam logic [7:0]  POINT_MS_RST    = 8'd20;
	localparam logic [3:0]  LANE_COUNT_RST  = 4'd3;
	localparam logic [3:0]  MAX_LANES       = 4'd8;

	// milliseconds to seconds: ceil(2^38 / 1000) in 16-bit halves
	localparam logic [15:0] RECIP_HI = 16'h1062;
	localparam logic [15:0] RECIP_LO = 16'h4DD3;

	localparam logic [4:0] ROOT_STEPS = 5'd15;
	localparam logic [4:0] DIV_STEPS  = 5'd3;

endpackage

@@ src/lane_change_decision.sv @@
// ----------------------------------------------------------------------------
// lane_change_decision
// Frame-based lane change and reference speed decision.
// ----------------------------------------------------------------------------
// A begin transaction loads the ego data without stalling the input, a finish
// transaction writes the decision into the output register (it waits in a hold
// state only while the output register is still full and stalled). A vehicle
// transaction keeps s_tready low until the vehicle unit is done with it:
// two squaring steps, two projection multiplies and four partial products
// of a reciprocal divide by 1000 on one shared 17x17 multiplier, a 16-step
// square root on one subtractor, and a final gap check.
// ----------------------------------------------------------------------------
module lane_change_decision
	import lcd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// ego_s, ego_lane, ref_speed, prev_points, car_s, car_d, car_vx, car_vy
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// action
	input  logic [IN_USER_W-1:0]  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// chosen lane, updated ref speed, lane_blocked
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [2:0]            cfg_index,
	input  logic [15:0]           cfg_data
);

	lcd_top_state_t state_q, state_d;

	logic [15:0] follow_gap_q, rear_gap_q, speed_limit_q;
	logic [11:0] speed_step_q;
	logic [7:0]  point_ms_q;
	logic [3:0]  lane_count_q;

	logic [23:0] held_ego_s_q;
	logic [2:0]  held_lane_q;
	logic [15:0] held_speed_q;
	logic [7:0]  held_points_q;
	logic        ahead_blocked_q, left_free_q, right_free_q;

	logic [OUT_DATA_W-1:0] out_q, pend_q;
	logic                  out_valid_q;

	lcd_action_t act;
	logic        in_fire, out_free, veh_start;
	lcd_vstat_t  vstat;

	logic [2:0]  in_lane;
	logic [3:0]  lanes;
	logic [2:0]  res_lane;
	logic [15:0] res_speed;
	logic [16:0] spd_sum;
	logic [OUT_DATA_W-1:0] res_word;

	logic signed [4:0] cl5, ln5, lm1, lp1;

	assign act       = lcd_action_t'(s_tuser);
	assign in_fire   = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;
	assign veh_start = in_fire && (act == ACT_VEHICLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_q;
	assign in_lane   = s_tdata[EGO_LANE_LO +: 3];
	assign lanes     = (lane_count_q > MAX_LANES) ? MAX_LANES : lane_count_q;

	lcd_vehicle_unit u_veh (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (veh_start),
		.car_s      (s_tdata[CAR_S_LO +: 24]),
		.car_d      ($signed(s_tdata[CAR_D_LO +: 14])),
		.car_vx     ($signed(s_tdata[CAR_VX_LO +: 16])),
		.car_vy     ($signed(s_tdata[CAR_VY_LO +: 16])),
		.points     (held_points_q),
		.period     (point_ms_q),
		.ego_s      (held_ego_s_q),
		.follow_gap (follow_gap_q),
		.rear_gap   (rear_gap_q),
		.stat       (vstat)
	);

	// decision from the held frame state
	always_comb begin
		res_lane  = held_lane_q;
		res_speed = held_speed_q;
		spd_sum   = {1'b0, held_speed_q} + {5'd0, speed_step_q};
		if (ahead_blocked_q) begin
			res_speed = (held_speed_q > {4'd0, speed_step_q}) ?
				held_speed_q - {4'd0, speed_step_q} : 16'd0;
			if (left_free_q && held_lane_q != 3'd0) begin
				res_lane = held_lane_q - 3'd1;
			end else if (right_free_q) begin
				res_lane = held_lane_q + 3'd1;
			end
		end else if (held_speed_q < speed_limit_q) begin
			res_speed = spd_sum[16] ? 16'hFFFF : spd_sum[15:0];
		end
		res_word = {4'd0, ahead_blocked_q, res_speed, res_lane};
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			TOP_IDLE: begin
				if (in_fire && act == ACT_VEHICLE) state_d = TOP_BUSY;
				else if (in_fire && act == ACT_FINISH && !out_free) state_d = TOP_HOLD;
			end
			TOP_BUSY: if (vstat.done) state_d = TOP_IDLE;
			TOP_HOLD: if (out_free) state_d = TOP_IDLE;
			default:  state_d = TOP_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		unique case (state_q)
			TOP_IDLE: s_tready = 1'b1;
			default:  s_tready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= TOP_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			follow_gap_q  <= FOLLOW_GAP_RST;
			rear_gap_q    <= REAR_GAP_RST;
			speed_step_q  <= SPEED_STEP_RST;
			speed_limit_q <= SPEED_LIMIT_RST;
			point_ms_q    <= POINT_MS_RST;
			lane_count_q  <= LANE_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (lcd_reg_t'(cfg_index))
				REG_FOLLOW_GAP:  follow_gap_q  <= cfg_data;
				REG_REAR_GAP:    rear_gap_q    <= cfg_data;
				REG_SPEED_STEP:  speed_step_q  <= cfg_data[11:0];
				REG_SPEED_LIMIT: speed_limit_q <= cfg_data;
				REG_POINT_MS:    point_ms_q    <= cfg_data[7:0];
				REG_LANE_COUNT:  lane_count_q  <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	// lane index comparisons on small signed values
	assign cl5 = {vstat.clane[3], vstat.clane};
	assign ln5 = $signed({2'b00, held_lane_q});
	assign lm1 = ln5 - 5'sd1;
	assign lp1 = ln5 + 5'sd1;

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_ego_s_q    <= '0;
			held_lane_q     <= '0;
			held_speed_q    <= '0;
			held_points_q   <= '0;
			ahead_blocked_q <= 1'b0;
			left_free_q     <= 1'b0;
			right_free_q    <= 1'b0;
		end else if (in_fire && act == ACT_BEGIN) begin
			held_ego_s_q    <= s_tdata[EGO_S_LO +: 24];
			held_lane_q     <= in_lane;
			held_speed_q    <= s_tdata[REF_SPD_LO +: 16];
			held_points_q   <= s_tdata[POINTS_LO +: 8];
			ahead_blocked_q <= 1'b0;
			left_free_q     <= (in_lane != 3'd0);
			right_free_q    <= ({1'b0, in_lane} + 4'd1) < lanes;
		end else if (vstat.done && vstat.close) begin
			if (cl5 == ln5 && vstat.ahead) begin
				ahead_blocked_q <= 1'b1;
			end else if (cl5 == lm1) begin
				left_free_q <= 1'b0;
			end else if (cl5 == lp1) begin
				right_free_q <= 1'b0;
			end
		end
	end

	// output register with a one-entry hold for a stalled finish
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire && act == ACT_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (state_q == TOP_HOLD && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && act == ACT_FINISH) begin
			pend_q <= res_word;
		end
		if (in_fire && act == ACT_FINISH && out_free) begin
			out_q <= res_word;
		end else if (state_q == TOP_HOLD && out_free) begin
			out_q <= pend_q;
		end
	end

endmodule

@@ src/lcd_vehicle_unit.sv @@
// ----------------------------------------------------------------------------
// lcd_vehicle_unit
// Iterative evaluation of one other vehicle: squares, the projection and a
// reciprocal multiply for the divide by 1000 through a shared multiplier, a
// bit-pair square root through a subtractor, then the gap and lane verdict.
// ----------------------------------------------------------------------------
module lcd_vehicle_unit
	import lcd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [23:0]        car_s,
	input  logic signed [13:0] car_d,
	input  logic signed [15:0] car_vx,
	input  logic signed [15:0] car_vy,
	input  logic [7:0]         points,
	input  logic [7:0]         period,
	input  logic [23:0]        ego_s,
	input  logic [15:0]        follow_gap,
	input  logic [15:0]        rear_gap,
	output lcd_vstat_t         stat
);

	lcd_unit_state_t state_q, state_d;
	logic [4:0]         cnt_q;
	logic [23:0]        s_q;
	logic signed [13:0] d_q;
	logic signed [15:0] vx_q, vy_q;
	logic [31:0]        acc_q;
	logic [31:0]        rad_q;
	logic [17:0]        rem_q;
	logic [15:0]        root_q;
	logic [15:0]        pp_q;
	logic [31:0]        x_q;

	logic signed [16:0] mul_a, mul_b;
	logic signed [33:0] prod;
	logic [19:0]        sub_a, sub_b;
	logic [20:0]        sub_y;
	logic               sub_lt;

	logic [24:0]        cs;
	logic signed [25:0] diff;
	logic signed [25:0] fol_s, rear_neg;
	logic               ahead;

	assign prod   = mul_a * mul_b;
	assign sub_y  = {1'b0, sub_a} - {1'b0, sub_b};
	assign sub_lt = sub_y[20];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			U_IDLE: if (start) state_d = U_SQA;
			U_SQA:  state_d = U_SQB;
			U_SQB:  state_d = U_ROOT;
			U_ROOT: if (cnt_q == '0) state_d = U_PP;
			U_PP:   state_d = U_PS;
			U_PS:   state_d = U_DIV;
			U_DIV:  if (cnt_q == '0) state_d = U_GAP;
			U_GAP:  state_d = U_IDLE;
			default: state_d = U_IDLE;
		endcase
	end

	// operand selection for the shared units
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		sub_a = '0;
		sub_b = '0;
		unique case (state_q)
			U_SQA: begin
				mul_a = {vx_q[15], vx_q};
				mul_b = {vx_q[15], vx_q};
			end
			U_SQB: begin
				mul_a = {vy_q[15], vy_q};
				mul_b = {vy_q[15], vy_q};
			end
			U_ROOT: begin
				sub_a = {rem_q, rad_q[31:30]};
				sub_b = {2'b00, root_q, 2'b01};
			end
			U_PP: begin
				mul_a = {9'd0, points};
				mul_b = {9'd0, period};
			end
			U_PS: begin
				mul_a = {1'b0, pp_q};
				mul_b = {1'b0, root_q};
			end
			U_DIV: begin
				// low half of the product first, odd steps take the low reciprocal half
				mul_a = (cnt_q > 5'd1) ? {1'b0, x_q[15:0]} : {1'b0, x_q[31:16]};
				mul_b = cnt_q[0] ? {1'b0, RECIP_LO} : {1'b0, RECIP_HI};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				U_SQB:  cnt_q <= ROOT_STEPS;
				U_PS:   cnt_q <= DIV_STEPS;
				U_ROOT, U_DIV: cnt_q <= cnt_q - 5'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			U_IDLE: begin
				if (start) begin
					s_q  <= car_s;
					d_q  <= car_d;
					vx_q <= car_vx;
					vy_q <= car_vy;
				end
			end
			U_SQA: acc_q <= prod[31:0];
			U_SQB: begin
				rad_q  <= acc_q + prod[31:0];
				rem_q  <= '0;
				root_q <= '0;
			end
			U_ROOT: begin
				rad_q  <= {rad_q[29:0], 2'b00};
				rem_q  <= sub_lt ? sub_a[17:0] : sub_y[17:0];
				root_q <= {root_q[14:0], ~sub_lt};
			end
			U_PP: pp_q <= prod[15:0];
			U_PS: x_q <= prod[31:0];
			U_DIV: begin
				// 16 low bits dropped after the first and the third partial product
				unique case (cnt_q)
					5'd3:    acc_q <= prod[31:0];
					5'd1:    acc_q <= acc_q + prod[31:0];
					default: acc_q <= {16'd0, acc_q[31:16]} + prod[31:0];
				endcase
			end
			default: begin
			end
		endcase
	end

	// gap and lane verdict, taken in the last step
	// quotient is the accumulated product shifted down by six more bits
	assign cs       = {1'b0, s_q} + {3'd0, acc_q[27:6]};
	assign diff     = $signed({1'b0, cs}) - $signed({2'b00, ego_s});
	assign fol_s    = $signed({10'd0, follow_gap});
	assign rear_neg = -$signed({10'd0, rear_gap});
	assign ahead    = !diff[25] && (diff != '0);

	always_comb begin
		stat.done  = (state_q == U_GAP);
		stat.ahead = ahead;
		stat.close = ahead ? (diff < fol_s) : (diff > rear_neg);
		stat.clane = d_q[13:10];
	end

endmodule

@@ src/lcd_checker.sv @@
// ----------------------------------------------------------------------------
// lcd_checker
// Port-level checks of the lane change decision block, bound to the top.
// ----------------------------------------------------------------------------
module lcd_port_checker
	import lcd_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic [IN_USER_W-1:0]  s_tuser,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// vehicle evaluation occupies the unit
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == ACT_VEHICLE |=> !s_tready)
		else $error("ready during vehicle evaluation");

	// begin does not stall the input
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == ACT_BEGIN |=> s_tready)
		else $error("begin transaction stalled the input");

	// finish into an empty output register shows the result next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == ACT_FINISH && !m_tvalid |=> m_tvalid)
		else $error("finish result not presented");

endmodule

bind lane_change_decision lcd_port_checker u_lcd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
